>>> hw/rtl/ssnc_pkg.sv
// ----------------------------------------------------------------------------
// ssnc_pkg: shared types and constants of the slot sync neighbor counter
// Command codes, configuration register indexes, reset values and the
// control bundle that drives the neighbor table.
// ----------------------------------------------------------------------------
package ssnc_pkg;

    // Item commands
    typedef enum logic [1:0] {
        CMD_CALL      = 2'd0,
        CMD_CYCLE_END = 2'd1,
        CMD_TICK      = 2'd2
    } cmd_t;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CYCLE_LIMIT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BLINKS      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOTOR_ON_MS     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOTOR_OFF_MS    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UPDATE_INTERVAL = 3'd4;

    // Configuration reset values
    localparam logic [7:0]  RST_CYCLE_LIMIT     = 8'd10;
    localparam logic [7:0]  RST_MAX_BLINKS      = 8'd10;
    localparam logic [15:0] RST_MOTOR_ON_MS     = 16'd100;
    localparam logic [15:0] RST_MOTOR_OFF_MS    = 16'd300;
    localparam logic [15:0] RST_UPDATE_INTERVAL = 16'd1000;

    // Node state reset values
    localparam logic [7:0]  RST_NODE_ADDRESS = 8'd1;
    localparam logic [15:0] TIMER_MAX        = 16'hFFFF;

    // Neighbor table control from the sequencer
    typedef struct packed {
        logic start;   // look up the key and append it if absent
        logic clear;   // empty the table
    } tbl_ctrl_t;

endpackage

>>> hw/rtl/ssnc_item_if.sv
// ----------------------------------------------------------------------------
// ssnc_item_if: input item channel
// Valid/ready channel that carries one command beat into the node logic.
// ----------------------------------------------------------------------------
interface ssnc_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] alien_address;
    logic [7:0] alien_cycle;

    modport source (output valid, command, alien_address, alien_cycle, input ready);
    modport sink   (input valid, command, alien_address, alien_cycle, output ready);
endinterface

>>> hw/rtl/ssnc_result_if.sv
// ----------------------------------------------------------------------------
// ssnc_result_if: result channel
// Valid/ready channel that carries one node status beat per input item.
// ----------------------------------------------------------------------------
interface ssnc_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] own_address;
    logic [7:0] cycle_count;
    logic       transmit_enable;
    logic       realign_req;
    logic [7:0] adjust_address;
    logic       motor_drive;
    logic [5:0] neighbors_seen;
    logic [7:0] blinks_left;

    modport source (output valid, own_address, cycle_count, transmit_enable,
                    realign_req, adjust_address, motor_drive, neighbors_seen,
                    blinks_left, input ready);
    modport sink   (input valid, own_address, cycle_count, transmit_enable,
                    realign_req, adjust_address, motor_drive, neighbors_seen,
                    blinks_left, output ready);
endinterface

>>> hw/rtl/ssnc_table.sv
// ----------------------------------------------------------------------------
// ssnc_table: neighbor address table with a serial lookup
// Holds the distinct neighbor addresses in a memory and a fill count. A
// start walks the filled entries one read a cycle through a single
// comparator and appends the key when no entry matches and room remains.
// ----------------------------------------------------------------------------
module ssnc_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ssnc_pkg::tbl_ctrl_t            ctrl,
    input  logic [7:0]                     key,
    output logic                           done,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] total
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [0:0] {
        T_IDLE,
        T_SCAN
    } tstate_t;

    tstate_t         state_reg;
    logic [CW-1:0]   idx_reg;
    logic [CW-1:0]   total_reg;
    logic            pend_reg;
    logic            done_reg;
    logic [7:0]      key_reg;
    logic [7:0]      rd_data_reg;
    logic [7:0]      mem [TABLE_DEPTH];

    logic issue;
    logic hit;
    logic finish;
    logic append;

    // Comparator and walk control
    always_comb
    begin
        issue  = (state_reg == T_SCAN) && (idx_reg < total_reg);
        hit    = (state_reg == T_SCAN) && pend_reg && (rd_data_reg == key_reg);
        finish = (state_reg == T_SCAN) && !hit && !issue && !pend_reg;
        append = finish && (total_reg < CW'(TABLE_DEPTH));
    end

    // Sequencer, fill count and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            idx_reg   <= '0;
            total_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                T_IDLE:
                begin
                    if (ctrl.clear)
                    begin
                        total_reg <= '0;
                    end
                    if (ctrl.start)
                    begin
                        idx_reg   <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= T_SCAN;
                    end
                end
                T_SCAN:
                begin
                    pend_reg <= issue;
                    if (issue)
                    begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                    if (append)
                    begin
                        total_reg <= total_reg + CW'(1);
                    end
                    if (hit || finish)
                    begin
                        state_reg <= T_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    // Table memory: one write or one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.start && (state_reg == T_IDLE))
        begin
            key_reg <= key;
        end
        if (append)
        begin
            mem[total_reg[AW-1:0]] <= key_reg;
        end
        if (issue)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    assign done  = done_reg;
    assign total = total_reg;

endmodule

>>> hw/rtl/slot_sync_neighbor_counter.sv
// ----------------------------------------------------------------------------
// slot_sync_neighbor_counter: slotted radio node control
// Address arbitration, slot cycle sync, neighbor counting and motor blinks.
// ----------------------------------------------------------------------------
// Cycle end, tick and own-address CALL beats go straight to the response state
// after acceptance; other CALL beats first wait for the table walk over the N
// neighbors held, which ends early on a match. A new item is not taken until
// the result of the last one is loaded, and a result stall holds it off.
// Reset: asynchronous, active low; node state and registers take their reset
// values, the table is empty by its fill count with no clearing pass.
module slot_sync_neighbor_counter #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    ssnc_item_if.sink                              item_ch,
    ssnc_result_if.source                          result_ch,
    input  logic                                   cfg_we,
    input  logic [ssnc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [ssnc_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;
    localparam int TW   = (CW > 6) ? CW : 6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ON,
        PH_OFF
    } phase_t;

    // Configuration registers
    logic [7:0]  cycle_limit_reg;
    logic [7:0]  max_blinks_reg;
    logic [15:0] motor_on_reg;
    logic [15:0] motor_off_reg;
    logic [15:0] update_interval_reg;

    // Node state
    state_t      state_reg,   state_next;
    logic [7:0]  node_reg,    node_next;
    logic [7:0]  slot_reg,    slot_next;
    logic        tx_reg,      tx_next;
    logic [7:0]  blink_reg,   blink_next;
    phase_t      phase_reg,   phase_next;
    logic [15:0] btimer_reg,  btimer_next;
    logic [15:0] utimer_reg,  utimer_next;
    logic        adj_reg,     adj_next;
    logic [7:0]  adj_addr_reg, adj_addr_next;
    logic        out_valid_reg, out_valid_next;

    // Result payload
    logic [7:0]  res_own_reg;
    logic [7:0]  res_cycle_reg;
    logic        res_tx_reg;
    logic        res_adj_reg;
    logic [7:0]  res_adj_addr_reg;
    logic        res_motor_reg;
    logic [5:0]  res_seen_reg;
    logic [7:0]  res_blinks_reg;

    ssnc_pkg::tbl_ctrl_t tbl_ctrl;
    logic                tbl_done;
    logic [CW-1:0]       tbl_total;

    logic            accept;
    logic            load;
    logic [15:0]     btimer_inc;
    logic [15:0]     utimer_inc;
    logic [7:0]      slot_inc;
    logic            update_due;
    logic [CMPW-1:0] total_ext;
    logic [CMPW-1:0] max_ext;
    logic [TW-1:0]   seen_ext;
    logic [7:0]      blink_dec;

    ssnc_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tbl_ctrl),
        .key   (item_ch.alien_address),
        .done  (tbl_done),
        .total (tbl_total)
    );

    // Shared helper values
    assign accept     = item_ch.valid && item_ch.ready;
    assign btimer_inc = (btimer_reg == ssnc_pkg::TIMER_MAX) ? btimer_reg
                                                            : btimer_reg + 16'd1;
    assign utimer_inc = (utimer_reg == ssnc_pkg::TIMER_MAX) ? utimer_reg
                                                            : utimer_reg + 16'd1;
    assign slot_inc   = slot_reg + 8'd1;
    assign update_due = (slot_reg == 8'd0) && (utimer_reg >= update_interval_reg);
    assign total_ext  = CMPW'(tbl_total);
    assign max_ext    = CMPW'(max_blinks_reg);
    assign seen_ext   = TW'(tbl_total);
    assign blink_dec  = blink_reg - 8'd1;

    // Sequencer and next node state
    always_comb
    begin
        state_next     = state_reg;
        node_next      = node_reg;
        slot_next      = slot_reg;
        tx_next        = tx_reg;
        blink_next     = blink_reg;
        phase_next     = phase_reg;
        btimer_next    = btimer_reg;
        utimer_next    = utimer_reg;
        adj_next       = adj_reg;
        adj_addr_next  = adj_addr_reg;
        tbl_ctrl       = '0;
        load           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    adj_next      = 1'b0;
                    adj_addr_next = 8'd0;
                    state_next    = S_RESP;
                    case (ssnc_pkg::cmd_t'(item_ch.command))
                        ssnc_pkg::CMD_CALL:
                        begin
                            if (item_ch.alien_address == node_reg)
                            begin
                                adj_next      = 1'b1;
                                adj_addr_next = item_ch.alien_address;
                                slot_next     = item_ch.alien_cycle;
                                tx_next       = 1'b0;
                                node_next     = node_reg + 8'd1;
                            end
                            else
                            begin
                                if (item_ch.alien_address < node_reg)
                                begin
                                    adj_next      = 1'b1;
                                    adj_addr_next = item_ch.alien_address;
                                    slot_next     = item_ch.alien_cycle;
                                end
                                tbl_ctrl.start = 1'b1;
                                state_next     = S_WAIT;
                            end
                        end
                        ssnc_pkg::CMD_CYCLE_END:
                        begin
                            if (update_due)
                            begin
                                utimer_next    = 16'd0;
                                blink_next     = (total_ext > max_ext) ? max_blinks_reg
                                                                       : 8'(total_ext);
                                tbl_ctrl.clear = 1'b1;
                            end
                            if (slot_inc >= cycle_limit_reg)
                            begin
                                slot_next = 8'd0;
                                tx_next   = 1'b1;
                            end
                            else
                            begin
                                slot_next = slot_inc;
                            end
                        end
                        ssnc_pkg::CMD_TICK:
                        begin
                            btimer_next = btimer_inc;
                            utimer_next = utimer_inc;
                            if (blink_reg != 8'd0)
                            begin
                                case (phase_reg)
                                    PH_IDLE:
                                    begin
                                        btimer_next = 16'd0;
                                        phase_next  = PH_ON;
                                    end
                                    PH_ON:
                                    begin
                                        if (btimer_inc >= motor_on_reg)
                                        begin
                                            btimer_next = 16'd0;
                                            phase_next  = PH_OFF;
                                        end
                                    end
                                    default:
                                    begin
                                        if (btimer_inc >= motor_off_reg)
                                        begin
                                            blink_next = blink_dec;
                                            if (blink_dec != 8'd0)
                                            begin
                                                btimer_next = 16'd0;
                                                phase_next  = PH_ON;
                                            end
                                            else
                                            begin
                                                phase_next = PH_IDLE;
                                            end
                                        end
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                if (tbl_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Hold the result beat until taken, refill on load
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            node_reg      <= ssnc_pkg::RST_NODE_ADDRESS;
            slot_reg      <= 8'd0;
            tx_reg        <= 1'b0;
            blink_reg     <= 8'd0;
            phase_reg     <= PH_IDLE;
            btimer_reg    <= 16'd0;
            utimer_reg    <= 16'd0;
            adj_reg       <= 1'b0;
            adj_addr_reg  <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            node_reg      <= node_next;
            slot_reg      <= slot_next;
            tx_reg        <= tx_next;
            blink_reg     <= blink_next;
            phase_reg     <= phase_next;
            btimer_reg    <= btimer_next;
            utimer_reg    <= utimer_next;
            adj_reg       <= adj_next;
            adj_addr_reg  <= adj_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_limit_reg     <= ssnc_pkg::RST_CYCLE_LIMIT;
            max_blinks_reg      <= ssnc_pkg::RST_MAX_BLINKS;
            motor_on_reg        <= ssnc_pkg::RST_MOTOR_ON_MS;
            motor_off_reg       <= ssnc_pkg::RST_MOTOR_OFF_MS;
            update_interval_reg <= ssnc_pkg::RST_UPDATE_INTERVAL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ssnc_pkg::CFG_CYCLE_LIMIT:     cycle_limit_reg     <= cfg_data[7:0];
                ssnc_pkg::CFG_MAX_BLINKS:      max_blinks_reg      <= cfg_data[7:0];
                ssnc_pkg::CFG_MOTOR_ON_MS:     motor_on_reg        <= cfg_data;
                ssnc_pkg::CFG_MOTOR_OFF_MS:    motor_off_reg       <= cfg_data;
                ssnc_pkg::CFG_UPDATE_INTERVAL: update_interval_reg <= cfg_data;
                default:
                begin
                    cycle_limit_reg <= cycle_limit_reg;
                end
            endcase
        end
    end

    // Capture the result beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_own_reg      <= node_reg;
            res_cycle_reg    <= slot_reg;
            res_tx_reg       <= tx_reg;
            res_adj_reg      <= adj_reg;
            res_adj_addr_reg <= adj_addr_reg;
            res_motor_reg    <= (phase_reg == PH_ON);
            res_seen_reg     <= seen_ext[5:0];
            res_blinks_reg   <= blink_reg;
        end
    end

    assign item_ch.ready             = (state_reg == S_IDLE);
    assign result_ch.valid           = out_valid_reg;
    assign result_ch.own_address     = res_own_reg;
    assign result_ch.cycle_count     = res_cycle_reg;
    assign result_ch.transmit_enable = res_tx_reg;
    assign result_ch.realign_req     = res_adj_reg;
    assign result_ch.adjust_address  = res_adj_addr_reg;
    assign result_ch.motor_drive     = res_motor_reg;
    assign result_ch.neighbors_seen  = res_seen_reg;
    assign result_ch.blinks_left     = res_blinks_reg;

`ifndef NO_ASSERTIONS
    // The table reports completion only to a waiting sequencer
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_done |-> (state_reg == S_WAIT))
        else $error("table done outside wait state");

    // The fill count never passes the table depth
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CMPW'(tbl_total) <= CMPW'(TABLE_DEPTH)))
        else $error("neighbor count beyond table depth");

    // A blink count load empties the table
    a_clear_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item_ch.command == ssnc_pkg::CMD_CYCLE_END) && update_due)
        |=> (tbl_total == '0))
        else $error("table not emptied on blink load");
`endif

endmodule

>>> bench/node_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_status_checker: status predictor and scoreboard for the node logic
// Watches the item, result and register write ports, steps its own copy of
// the node state for every accepted item beat and compares each result beat,
// field by field, with the oldest predicted status.
// ----------------------------------------------------------------------------
module node_status_checker #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    ssnc_item_if                                 item_ch,
    ssnc_result_if                               result_ch,
    input  logic                                 cfg_we,
    input  logic [ssnc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ssnc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int unsigned                          fault_count,
    output int unsigned                          outstanding
);

    typedef enum logic [1:0] {
        BLINK_IDLE = 2'd0,
        BLINK_ON   = 2'd1,
        BLINK_OFF  = 2'd2
    } blink_phase_t;

    typedef struct packed {
        logic [7:0] own_address;
        logic [7:0] cycle_count;
        logic       transmit_enable;
        logic       realign_req;
        logic [7:0] adjust_address;
        logic       motor_drive;
        logic [5:0] neighbors_seen;
        logic [7:0] blinks_left;
    } node_status_t;

    // Register copies
    logic [7:0]  cycle_limit;
    logic [7:0]  blink_cap;
    logic [15:0] on_ticks;
    logic [15:0] off_ticks;
    logic [15:0] load_interval;

    // Node state copy
    logic [7:0]   node_addr;
    logic [7:0]   slot_cyc;
    logic         tx_on;
    logic [7:0]   nbr_table [TABLE_DEPTH];
    int unsigned  nbr_fill;
    logic [7:0]   blink_cnt;
    blink_phase_t phase;
    logic [15:0]  blink_tmr;
    logic [15:0]  update_tmr;

    node_status_t status_q [$];
    int unsigned  fails = 0;

    function automatic void reset_node();
        cycle_limit   = ssnc_pkg::RST_CYCLE_LIMIT;
        blink_cap     = ssnc_pkg::RST_MAX_BLINKS;
        on_ticks      = ssnc_pkg::RST_MOTOR_ON_MS;
        off_ticks     = ssnc_pkg::RST_MOTOR_OFF_MS;
        load_interval = ssnc_pkg::RST_UPDATE_INTERVAL;
        node_addr     = ssnc_pkg::RST_NODE_ADDRESS;
        slot_cyc      = 8'd0;
        tx_on         = 1'b0;
        nbr_fill      = 0;
        blink_cnt     = 8'd0;
        phase         = BLINK_IDLE;
        blink_tmr     = 16'd0;
        update_tmr    = 16'd0;
    endfunction

    // Append an address once; drop it when the table is full
    function automatic void note_neighbor(logic [7:0] addr);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (i < nbr_fill && nbr_table[i] == addr)
                hit = 1'b1;
        if (!hit && nbr_fill < TABLE_DEPTH)
        begin
            nbr_table[nbr_fill] = addr;
            nbr_fill++;
        end
    endfunction

    // Advance the blink sequence by one millisecond tick
    function automatic void blink_step();
        if (blink_cnt == 8'd0)
            return;
        case (phase)
            BLINK_IDLE:
            begin
                blink_tmr = 16'd0;
                phase     = BLINK_ON;
            end
            BLINK_ON:
            begin
                if (blink_tmr >= on_ticks)
                begin
                    blink_tmr = 16'd0;
                    phase     = BLINK_OFF;
                end
            end
            default:
            begin
                if (blink_tmr >= off_ticks)
                begin
                    blink_cnt = blink_cnt - 8'd1;
                    if (blink_cnt != 8'd0)
                    begin
                        blink_tmr = 16'd0;
                        phase     = BLINK_ON;
                    end
                    else
                    begin
                        phase = BLINK_IDLE;
                    end
                end
            end
        endcase
    endfunction

    // Step the node state for one item beat and return its status
    function automatic node_status_t advance_node(logic [1:0] cmd, logic [7:0] alien_addr,
                                                  logic [7:0] alien_cyc);
        node_status_t st;
        logic         adjust;
        logic [7:0]   adj_addr;
        adjust   = 1'b0;
        adj_addr = 8'd0;
        case (cmd)
            ssnc_pkg::CMD_CALL:
            begin
                if (alien_addr == node_addr)
                begin
                    adjust    = 1'b1;
                    adj_addr  = alien_addr;
                    slot_cyc  = alien_cyc;
                    tx_on     = 1'b0;
                    node_addr = node_addr + 8'd1;
                end
                else
                begin
                    if (alien_addr < node_addr)
                    begin
                        adjust   = 1'b1;
                        adj_addr = alien_addr;
                        slot_cyc = alien_cyc;
                    end
                    note_neighbor(alien_addr);
                end
            end
            ssnc_pkg::CMD_CYCLE_END:
            begin
                if (slot_cyc == 8'd0 && update_tmr >= load_interval)
                begin
                    update_tmr = 16'd0;
                    blink_cnt  = (nbr_fill > blink_cap) ? blink_cap : nbr_fill[7:0];
                    nbr_fill   = 0;
                end
                slot_cyc = slot_cyc + 8'd1;
                if (slot_cyc >= cycle_limit)
                begin
                    slot_cyc = 8'd0;
                    tx_on    = 1'b1;
                end
            end
            ssnc_pkg::CMD_TICK:
            begin
                if (blink_tmr != ssnc_pkg::TIMER_MAX)
                    blink_tmr = blink_tmr + 16'd1;
                if (update_tmr != ssnc_pkg::TIMER_MAX)
                    update_tmr = update_tmr + 16'd1;
                blink_step();
            end
            default:
            begin
            end
        endcase
        st.own_address     = node_addr;
        st.cycle_count     = slot_cyc;
        st.transmit_enable = tx_on;
        st.realign_req     = adjust;
        st.adjust_address  = adj_addr;
        st.motor_drive     = (phase == BLINK_ON);
        st.neighbors_seen  = nbr_fill[5:0];
        st.blinks_left     = blink_cnt;
        return st;
    endfunction

    function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fails++;
        end
    endfunction

    // Track register writes, predict on item beats, compare on result beats
    always @(posedge clk or negedge rst_n)
    begin
        node_status_t want;
        if (!rst_n)
        begin
            reset_node();
            status_q.delete();
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (status_q.size() == 0)
                begin
                    $error("result beat with no item pending");
                    fails++;
                end
                else
                begin
                    want = status_q.pop_front();
                    check_field("own_address", want.own_address, result_ch.own_address);
                    check_field("cycle_count", want.cycle_count, result_ch.cycle_count);
                    check_field("transmit_enable", want.transmit_enable,
                                result_ch.transmit_enable);
                    check_field("realign_req", want.realign_req, result_ch.realign_req);
                    check_field("adjust_address", want.adjust_address,
                                result_ch.adjust_address);
                    check_field("motor_drive", want.motor_drive, result_ch.motor_drive);
                    check_field("neighbors_seen", want.neighbors_seen,
                                result_ch.neighbors_seen);
                    check_field("blinks_left", want.blinks_left, result_ch.blinks_left);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    ssnc_pkg::CFG_CYCLE_LIMIT:     cycle_limit   = cfg_data[7:0];
                    ssnc_pkg::CFG_MAX_BLINKS:      blink_cap     = cfg_data[7:0];
                    ssnc_pkg::CFG_MOTOR_ON_MS:     on_ticks      = cfg_data;
                    ssnc_pkg::CFG_MOTOR_OFF_MS:    off_ticks     = cfg_data;
                    ssnc_pkg::CFG_UPDATE_INTERVAL: load_interval = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (item_ch.valid && item_ch.ready)
                status_q.push_back(advance_node(item_ch.command, item_ch.alien_address,
                                                item_ch.alien_cycle));
        end
        outstanding <= status_q.size();
        fault_count <= fails;
    end

endmodule

>>> bench/slot_sync_neighbor_counter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_sync_neighbor_counter_test: top of the node logic testbench
// Drives a directed set of item beats and then random phases under several
// register settings and idle patterns, with a long result stall, and gives
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module slot_sync_neighbor_counter_test;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         ITEMS_PER_PHASE = 240;
    localparam int         PHASES      = 6;
    localparam int         STALL_AFTER = 400;
    localparam int         STALL_LEN   = 250;
    localparam int         IDLE_LIMIT  = 4000;
    localparam int         TAIL_CYCLES = 40;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [ssnc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [ssnc_pkg::CFG_DATA_W-1:0]  cfg_data;
    int unsigned                      fault_count;
    int unsigned                      outstanding;

    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    logic [7:0]  own_guess    = ssnc_pkg::RST_NODE_ADDRESS;
    int unsigned results_taken = 0;
    logic        stall_done    = 1'b0;
    int unsigned quiet_cycles  = 0;

    ssnc_item_if   item_ch ();
    ssnc_result_if result_ch ();

    slot_sync_neighbor_counter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (item_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    node_status_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_ch     (item_ch),
        .result_ch   (result_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fault_count (fault_count),
        .outstanding (outstanding)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Offer one item beat, with a random gap first, and hold it until taken
    task automatic send_beat(logic [1:0] cmd, logic [7:0] alien_addr, logic [7:0] alien_cyc);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.command       <= cmd;
        item_ch.alien_address <= alien_addr;
        item_ch.alien_cycle   <= alien_cyc;
        if (cmd == ssnc_pkg::CMD_CALL && alien_addr == own_guess)
            own_guess = own_guess + 8'd1;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // Random beat, weighted toward address collisions and cycle zero
    task automatic random_beat();
        int unsigned pick;
        int unsigned sel;
        logic [7:0]  alien_addr;
        logic [7:0]  alien_cyc;
        pick = $urandom_range(99);
        if (pick < 44)
        begin
            sel = $urandom_range(99);
            if (sel < 45)
                alien_addr = own_guess;
            else if (sel < 60)
                alien_addr = own_guess - 8'($urandom_range(3, 1));
            else if (sel < 75)
                alien_addr = 8'($urandom_range(47));
            else
                alien_addr = 8'($urandom_range(255));
            sel = $urandom_range(99);
            if (sel < 35)
                alien_cyc = 8'd0;
            else if (sel < 60)
                alien_cyc = 8'($urandom_range(3));
            else
                alien_cyc = 8'($urandom_range(255));
            send_beat(ssnc_pkg::CMD_CALL, alien_addr, alien_cyc);
        end
        else if (pick < 70)
            send_beat(ssnc_pkg::CMD_CYCLE_END, 8'($urandom_range(255)),
                      8'($urandom_range(255)));
        else if (pick < 97)
            send_beat(ssnc_pkg::CMD_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
        else
            send_beat(CMD_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    // Drop valid and wait until every predicted status has come back
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [ssnc_pkg::CFG_INDEX_W-1:0] index,
                             logic [ssnc_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Load one register setting per phase; extremes come first
    task automatic apply_setting(int phase_no);
        logic [15:0] vals [5];
        case (phase_no)
            0:       vals = '{16'd1,   16'd0,   16'd1,     16'd1,     16'd1};
            1:       vals = '{16'd255, 16'd0,   16'd65535, 16'd65535, 16'd65535};
            2:       vals = '{16'd4,   16'd5,   16'd3,     16'd2,     16'd20};
            3:       vals = '{16'd10,  16'd12,  16'd2,     16'd4,     16'd8};
            4:       vals = '{16'd2,   16'd3,   16'd1,     16'd2,     16'd3};
            default: vals = '{16'd7,   16'd255, 16'd4,     16'd1,     16'd50};
        endcase
        if (phase_no == 0)
            vals[1] = 16'd255;
        write_reg(ssnc_pkg::CFG_CYCLE_LIMIT, vals[0]);
        write_reg(ssnc_pkg::CFG_MAX_BLINKS, vals[1]);
        write_reg(ssnc_pkg::CFG_MOTOR_ON_MS, vals[2]);
        write_reg(ssnc_pkg::CFG_MOTOR_OFF_MS, vals[3]);
        write_reg(ssnc_pkg::CFG_UPDATE_INTERVAL, vals[4]);
        cfg_we <= 1'b0;
    endtask

    // Result side: random ready, one long hold-off to back the block up
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                results_taken++;
            if (!stall_done && results_taken == STALL_AFTER)
            begin
                stall_done = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (STALL_LEN) @(posedge clk);
            end
            result_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus and verdict
    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = ssnc_pkg::CFG_CYCLE_LIMIT;
        cfg_data              = '0;
        item_ch.valid         = 1'b0;
        item_ch.command       = ssnc_pkg::CMD_CALL;
        item_ch.alien_address = 8'd0;
        item_ch.alien_cycle   = 8'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats under reset register values
        snd_idle_pct = 25;
        rcv_idle_pct = 46;
        send_beat(ssnc_pkg::CMD_CALL, own_guess, 8'd0);
        send_beat(ssnc_pkg::CMD_CALL, 8'd0, 8'd255);
        send_beat(ssnc_pkg::CMD_CALL, 8'd255, 8'd255);
        send_beat(ssnc_pkg::CMD_CALL, 8'd255, 8'd0);
        send_beat(ssnc_pkg::CMD_CALL, own_guess, 8'd9);
        send_beat(ssnc_pkg::CMD_CYCLE_END, 8'd0, 8'd0);
        send_beat(ssnc_pkg::CMD_TICK, 8'd0, 8'd0);
        send_beat(CMD_UNUSED, 8'hFF, 8'hFF);
        send_beat(ssnc_pkg::CMD_CALL, own_guess, 8'd0);
        send_beat(ssnc_pkg::CMD_CYCLE_END, 8'hFF, 8'hFF);
        send_beat(ssnc_pkg::CMD_CALL, 8'hAA, 8'h55);
        send_beat(ssnc_pkg::CMD_CALL, 8'h55, 8'hAA);
        send_beat(ssnc_pkg::CMD_CALL, 8'h55, 8'h00);
        send_beat(ssnc_pkg::CMD_CALL, 8'd1, 8'd255);
        repeat (5) send_beat(ssnc_pkg::CMD_TICK, 8'hFF, 8'h00);
        send_beat(ssnc_pkg::CMD_CYCLE_END, 8'd0, 8'd0);

        // Random phases: receiver-heavy idling, then sender-heavy, then none
        for (int phase_no = 0; phase_no < PHASES; phase_no++)
        begin
            drain();
            apply_setting(phase_no);
            if (phase_no < 2)
            begin
                snd_idle_pct = 25;
                rcv_idle_pct = 46;
            end
            else if (phase_no < 4)
            begin
                snd_idle_pct = 46;
                rcv_idle_pct = 25;
            end
            else
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            repeat (ITEMS_PER_PHASE) random_beat();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
